FILE: src/lbe_pkg.sv
// shared types and constants of the led brightness estimator
`timescale 1ns / 1ps

package lbe_pkg;

  // field widths
  localparam int unsigned TS_W     = 48;
  localparam int unsigned CUR_W    = 16;
  localparam int unsigned MC_W     = 15;
  localparam int unsigned WIN_W    = 32;
  localparam int unsigned CHARGE_W = 64;
  localparam int unsigned LEVEL_W  = 9;
  localparam int unsigned RATIO_W  = 17;
  localparam int unsigned DEN_W    = TS_W + MC_W;
  localparam int unsigned ROOT_W   = 32;
  localparam int unsigned CFG_W    = 32;

  // configuration register indexes
  localparam logic CFG_MAX_CURRENT    = 1'b0;
  localparam logic CFG_REFRESH_WINDOW = 1'b1;

  // reset values of the configuration registers
  localparam logic [MC_W-1:0]  MAX_CURRENT_RST    = 15'd30000;
  localparam logic [WIN_W-1:0] REFRESH_WINDOW_RST = 32'd1000000;

  // level arithmetic
  localparam logic [LEVEL_W-1:0] LEVEL_OFF     = 9'd25;
  localparam logic [15:0]        LEVEL_SPAN_SQ = 16'd65025;
  localparam logic [RATIO_W-1:0] RATIO_ONE     = 17'h1_0000;
  localparam logic [ROOT_W-1:0]  ROOT_BIT_TOP  = 32'h4000_0000;

  // input opcodes
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_REFRESH = 1'b1;

  typedef struct packed {
    logic                    opcode;
    logic [TS_W-1:0]         time_stamp;
    logic signed [CUR_W-1:0] current_ua;
    logic                    running;
  } in_req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] brightness;
    logic               refreshed;
  } out_req_t;

endpackage

FILE: src/lbe_ratio_sqrt.sv
// duty ratio divider, scaling and square root giving the new level
`timescale 1ns / 1ps

module lbe_ratio_sqrt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [lbe_pkg::TS_W-1:0]          elapsed_i,
  input  logic [lbe_pkg::CHARGE_W-1:0]      charge_i,
  input  logic [lbe_pkg::MC_W-1:0]          max_current_i,
  output logic                              done_o,
  output logic [lbe_pkg::LEVEL_W-1:0]       level_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CMP,
    ST_DIV,
    ST_SCALE,
    ST_SQRT
  } state_e;

  state_e                          state_q;
  logic [3:0]                      cnt_q;
  logic [lbe_pkg::DEN_W-1:0]       md_q;
  logic [lbe_pkg::MC_W-1:0]        mcs_q;
  logic [lbe_pkg::DEN_W-1:0]       den_q;
  logic [lbe_pkg::CHARGE_W-1:0]    num_q;
  logic [lbe_pkg::DEN_W-1:0]       rem_q;
  logic [15:0]                     quo_q;
  logic [lbe_pkg::RATIO_W-1:0]     ratio_q;
  logic [lbe_pkg::ROOT_W-1:0]      x_q;
  logic [lbe_pkg::ROOT_W-1:0]      res_q;
  logic [lbe_pkg::ROOT_W-1:0]      bit_q;
  logic                            done_q;
  logic [lbe_pkg::LEVEL_W-1:0]     level_q;

  logic [lbe_pkg::DEN_W:0]         rem2;
  logic                            div_ge;
  logic [lbe_pkg::ROOT_W:0]        trial;
  logic                            root_ge;
  logic [lbe_pkg::ROOT_W-1:0]      res_next;
  logic [lbe_pkg::ROOT_W-1:0]      scaled;

  // one restoring division step
  assign rem2   = {rem_q, 1'b0};
  assign div_ge = rem2 >= {1'b0, den_q};

  // one square root step, two bits of the radicand at a time
  assign trial    = {1'b0, res_q} + {1'b0, bit_q};
  assign root_ge  = {1'b0, x_q} >= trial;
  assign res_next = root_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);

  // ratio times the squared span, at most 65025 * 65536 so it fits 32 bits
  assign scaled = 32'(lbe_pkg::LEVEL_SPAN_SQ) * 32'(ratio_q);

  // sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            md_q    <= {{lbe_pkg::MC_W{1'b0}}, elapsed_i};
            mcs_q   <= (max_current_i == '0) ? lbe_pkg::MC_W'(1) : max_current_i;
            den_q   <= '0;
            num_q   <= charge_i;
            cnt_q   <= '0;
            state_q <= ST_MUL;
          end
        end
        // shift and add, one bit of the maximum current a cycle
        ST_MUL: begin
          if (mcs_q[0]) begin
            den_q <= den_q + md_q;
          end
          md_q  <= {md_q[lbe_pkg::DEN_W-2:0], 1'b0};
          mcs_q <= mcs_q >> 1;
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'(lbe_pkg::MC_W - 1)) begin
            state_q <= ST_CMP;
          end
        end
        // ratio of one or more saturates
        ST_CMP: begin
          cnt_q <= '0;
          quo_q <= '0;
          if (num_q >= {1'b0, den_q}) begin
            ratio_q <= lbe_pkg::RATIO_ONE;
            state_q <= ST_SCALE;
          end else begin
            rem_q   <= num_q[lbe_pkg::DEN_W-1:0];
            state_q <= ST_DIV;
          end
        end
        // sixteen quotient bits, one a cycle
        ST_DIV: begin
          rem_q <= div_ge ? lbe_pkg::DEN_W'(rem2 - {1'b0, den_q})
                          : rem2[lbe_pkg::DEN_W-1:0];
          quo_q <= {quo_q[14:0], div_ge};
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            ratio_q <= {1'b0, quo_q[14:0], div_ge};
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          x_q     <= scaled;
          res_q   <= '0;
          bit_q   <= lbe_pkg::ROOT_BIT_TOP;
          cnt_q   <= '0;
          state_q <= ST_SQRT;
        end
        ST_SQRT: begin
          if (root_ge) begin
            x_q <= x_q - trial[lbe_pkg::ROOT_W-1:0];
          end
          res_q <= res_next;
          bit_q <= bit_q >> 2;
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            level_q <= {1'b0, res_next[15:8]} + lbe_pkg::LEVEL_OFF;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o  = done_q;
  assign level_o = level_q;

endmodule

FILE: src/led_brightness_estimator.sv
// led brightness estimator top level: bit-serial charge accumulation and control
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------
//   in      | sink      | in_valid_i / in_stall_o | in_data_i  (lbe_pkg::in_req_t)
//   out     | source    | out_valid_o / out_stall_i | out_data_o (lbe_pkg::out_req_t)
//   cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// one item at a time. a stopped refresh skips the bit-serial pass; a sample or a running
// refresh goes through the bit-serial pass over the charge accumulator, lsb first.
// a refresh that recomputes the level also runs the ratio unit (15 multiply, 16 divide
// and 16 square root steps; the divide steps are skipped when the ratio saturates).
// reset clears the time stamp, current and accumulator state and loads the level 25; no clearing pass is needed.
// a finished result sits in the output register while the next request is taken;
// a stalled output holds the following result back until it is taken.
`timescale 1ns / 1ps

module led_brightness_estimator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  lbe_pkg::in_req_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lbe_pkg::out_req_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [lbe_pkg::CFG_W-1:0]     cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHARGE,
    ST_CALC,
    ST_DONE
  } state_e;

  state_e                              state_q;
  logic [5:0]                          cnt_q;
  logic                                op_q;
  logic signed [lbe_pkg::CUR_W-1:0]    cur_q;
  logic [lbe_pkg::TS_W-1:0]            now_q;
  logic [lbe_pkg::TS_W-1:0]            prev_q;
  logic signed [lbe_pkg::CUR_W-1:0]    last_q;
  logic [lbe_pkg::TS_W-1:0]            elapsed_q;
  logic [lbe_pkg::CHARGE_W-1:0]        charge_q;
  logic [lbe_pkg::LEVEL_W-1:0]         level_q;
  logic                                borrow_q;
  logic                                ecarry_q;
  logic                                ccarry_q;
  logic [lbe_pkg::MC_W-1:0]            macc_q;
  logic                                gt_q;
  logic                                refreshed_q;
  logic                                start_q;
  logic [lbe_pkg::MC_W-1:0]            max_current_q;
  logic [lbe_pkg::WIN_W-1:0]           window_q;
  logic                                out_valid_q;
  lbe_pkg::out_req_t                   out_data_q;

  logic                                in_acc;
  logic                                out_free;
  logic                                in_lo;
  logic                                p_bit;
  logic                                borrow_d;
  logic [lbe_pkg::MC_W-1:0]            mcand;
  logic [lbe_pkg::MC_W:0]              mac_sum;
  logic                                prod_bit;
  logic                                e_bit;
  logic                                ecarry_d;
  logic                                c_bit;
  logic                                ccarry_d;
  logic                                w_bit;
  logic                                gt_d;
  logic                                calc_done;
  logic [lbe_pkg::LEVEL_W-1:0]         calc_level;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // bits of the time stamp still to come
  assign in_lo = (cnt_q < 6'(lbe_pkg::TS_W));

  // serial period: now minus previous time stamp
  assign p_bit    = in_lo & (now_q[0] ^ prev_q[0] ^ borrow_q);
  assign borrow_d = (!now_q[0] && (prev_q[0] || borrow_q)) || (prev_q[0] && borrow_q);

  // serial-parallel product of the previous current, if positive, and the period
  assign mcand    = (!last_q[lbe_pkg::CUR_W-1] && (last_q != '0))
                    ? last_q[lbe_pkg::MC_W-1:0] : '0;
  assign mac_sum  = {1'b0, macc_q} + (p_bit ? {1'b0, mcand} : '0);
  assign prod_bit = mac_sum[0];

  // serial adders for the elapsed ticks and the charge
  assign e_bit    = elapsed_q[0] ^ p_bit ^ ecarry_q;
  assign ecarry_d = (elapsed_q[0] & p_bit) | (elapsed_q[0] & ecarry_q) | (p_bit & ecarry_q);
  assign c_bit    = charge_q[0] ^ prod_bit ^ ccarry_q;
  assign ccarry_d = (charge_q[0] & prod_bit) | (charge_q[0] & ccarry_q) |
                    (prod_bit & ccarry_q);

  // serial compare of the new elapsed ticks against the window
  assign w_bit = (cnt_q < 6'(lbe_pkg::WIN_W)) ? window_q[cnt_q[4:0]] : 1'b0;
  assign gt_d  = (e_bit != w_bit) ? e_bit : gt_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_current_q <= lbe_pkg::MAX_CURRENT_RST;
      window_q      <= lbe_pkg::REFRESH_WINDOW_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        lbe_pkg::CFG_MAX_CURRENT:    max_current_q <= cfg_data_i[lbe_pkg::MC_W-1:0];
        lbe_pkg::CFG_REFRESH_WINDOW: window_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control, serial datapath and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      prev_q      <= '0;
      last_q      <= '0;
      elapsed_q   <= '0;
      charge_q    <= '0;
      level_q     <= lbe_pkg::LEVEL_OFF;
      refreshed_q <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            op_q        <= in_data_i.opcode;
            cur_q       <= in_data_i.current_ua;
            refreshed_q <= 1'b0;
            if (in_data_i.opcode == lbe_pkg::OP_REFRESH && !in_data_i.running) begin
              // stopped: clear and switch off
              charge_q  <= '0;
              elapsed_q <= '0;
              level_q   <= lbe_pkg::LEVEL_OFF;
              state_q   <= ST_DONE;
            end else begin
              now_q    <= in_data_i.time_stamp;
              cnt_q    <= '0;
              borrow_q <= 1'b0;
              ecarry_q <= 1'b0;
              ccarry_q <= 1'b0;
              macc_q   <= '0;
              gt_q     <= 1'b0;
              state_q  <= ST_CHARGE;
            end
          end
        end
        // one bit of every accumulator a cycle, lsb first; the 48-bit ones only while time stamp bits remain
        ST_CHARGE: begin
          cnt_q    <= cnt_q + 6'd1;
          macc_q   <= mac_sum[lbe_pkg::MC_W:1];
          ccarry_q <= ccarry_d;
          charge_q <= {c_bit, charge_q[lbe_pkg::CHARGE_W-1:1]};
          if (in_lo) begin
            now_q     <= now_q >> 1;
            prev_q    <= {now_q[0], prev_q[lbe_pkg::TS_W-1:1]};
            borrow_q  <= borrow_d;
            ecarry_q  <= ecarry_d;
            elapsed_q <= {e_bit, elapsed_q[lbe_pkg::TS_W-1:1]};
            gt_q      <= gt_d;
          end
          // elapsed ticks saturate; a saturated count always passes the window
          if (cnt_q == 6'(lbe_pkg::TS_W - 1) && ecarry_d) begin
            elapsed_q <= '1;
            gt_q      <= 1'b1;
          end
          if (cnt_q == 6'(lbe_pkg::CHARGE_W - 1)) begin
            if (ccarry_d) begin
              charge_q <= '1;
            end
            last_q <= cur_q;
            if (op_q == lbe_pkg::OP_REFRESH && gt_q) begin
              start_q <= 1'b1;
              state_q <= ST_CALC;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        // the ratio unit has taken the sums at start, so they clear now
        ST_CALC: begin
          if (start_q) begin
            charge_q  <= '0;
            elapsed_q <= '0;
          end
          if (calc_done) begin
            level_q     <= calc_level;
            refreshed_q <= 1'b1;
            state_q     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q           <= 1'b1;
            out_data_q.brightness <= level_q;
            out_data_q.refreshed  <= refreshed_q;
            state_q               <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // ratio, square root and level
  lbe_ratio_sqrt u_ratio_sqrt (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_q),
    .elapsed_i     (elapsed_q),
    .charge_i      (charge_q),
    .max_current_i (max_current_q),
    .done_o        (calc_done),
    .level_o       (calc_level)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: dv/tb_top.sv
// self-checking testbench of the led brightness estimator with directed and random requests
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned RESET_CYCLES    = 10;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 200;
  localparam int unsigned WATCHDOG_LIMIT  = 3000;
  localparam int unsigned REPORT_LIMIT    = 10;
  localparam int unsigned PHASE_ITEMS     = 210;

  localparam logic [8:0]      LEVEL_DARK   = 9'd25;
  localparam longint unsigned SPAN_SQUARED = 64'd65025;
  localparam longint unsigned Q16_ONE      = 64'd65536;
  localparam logic [47:0]     STAMP_MAX    = '1;
  localparam longint unsigned HALF_WRAP    = 64'h0000_8000_0000_0000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  lbe_pkg::in_req_t    in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  lbe_pkg::out_req_t   out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic                cfg_index_i;
  logic [31:0]         cfg_data_i;

  // shadow copy of the registers and state of the block
  logic [14:0]         full_scale_ua;
  logic [31:0]         window_ticks;
  logic [47:0]         last_stamp;
  logic signed [15:0]  held_current;
  logic [63:0]         charge_acc;
  logic [47:0]         ticks_acc;
  logic [8:0]          level_now;

  lbe_pkg::out_req_t   expected_levels[$];
  int unsigned         mismatch_count;
  int unsigned         quiet_cycles;
  bit                  burst_mode;
  bit                  hold_off_req;

  led_brightness_estimator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // floor of the square root, bit by bit from the top
  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  // duty ratio in q1.16, truncated, saturating at one
  function automatic longint unsigned duty_q16(longint unsigned num, longint unsigned den);
    logic [79:0] scaled;
    if (num >= den) return Q16_ONE;
    scaled = {num, 16'h0};
    return 64'(scaled / {16'h0, den});
  endfunction

  // charge the accumulators with the held current over the elapsed ticks
  function automatic void integrate_charge(logic [47:0] stamp, logic signed [15:0] cur);
    logic [47:0] span;
    logic [48:0] ticks_sum;
    logic [63:0] prod;
    logic [64:0] charge_sum;
    span = stamp - last_stamp;
    last_stamp = stamp;
    ticks_sum = {1'b0, ticks_acc} + {1'b0, span};
    ticks_acc = ticks_sum[48] ? STAMP_MAX : ticks_sum[47:0];
    if (held_current > 0) begin
      prod = {48'h0, held_current} * {16'h0, span};
      charge_sum = {1'b0, charge_acc} + {1'b0, prod};
      charge_acc = charge_sum[64] ? '1 : charge_sum[63:0];
    end
    held_current = cur;
  endfunction

  // expected result of one request, updating the shadow state
  function automatic lbe_pkg::out_req_t predict_level(lbe_pkg::in_req_t req);
    lbe_pkg::out_req_t res;
    longint unsigned   scale;
    longint unsigned   duty;
    res.refreshed = 1'b0;
    if (req.opcode == lbe_pkg::OP_SAMPLE) begin
      integrate_charge(req.time_stamp, req.current_ua);
    end else if (!req.running) begin
      charge_acc = '0;
      ticks_acc = '0;
      level_now = LEVEL_DARK;
    end else begin
      integrate_charge(req.time_stamp, req.current_ua);
      if (ticks_acc > {16'h0, window_ticks}) begin
        scale = (full_scale_ua == 0) ? 64'd1 : 64'(full_scale_ua);
        duty = duty_q16(charge_acc, 64'(ticks_acc) * scale);
        level_now = LEVEL_DARK + 9'(root_floor(SPAN_SQUARED * duty) >> 8);
        charge_acc = '0;
        ticks_acc = '0;
        res.refreshed = 1'b1;
      end
    end
    res.brightness = level_now;
    return res;
  endfunction

  function automatic lbe_pkg::in_req_t make_req(logic op, logic [47:0] stamp,
                                                logic [15:0] cur, logic run);
    lbe_pkg::in_req_t req;
    req.opcode = op;
    req.time_stamp = stamp;
    req.current_ua = cur;
    req.running = run;
    return req;
  endfunction

  function automatic logic [47:0] rand_stamp();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // gap length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned pick;
    if (burst_mode) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 16);
    return $urandom_range(40, 150);
  endfunction

  // offer one request and wait until it is taken
  task automatic send_req(lbe_pkg::in_req_t req);
    int unsigned gap;
    gap = idle_len();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i = req;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    expected_levels.push_back(predict_level(req));
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_levels.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == lbe_pkg::CFG_MAX_CURRENT) begin
      full_scale_ua = data[14:0];
    end else begin
      window_ticks = data;
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // reset configuration: field extremes, stopped refresh, backwards time stamp
  task automatic test_basic_levels();
    send_req(make_req(lbe_pkg::OP_SAMPLE, 48'd0, 16'd0, 1'b0));
    send_req(make_req(lbe_pkg::OP_SAMPLE, 48'd100, 16'h7fff, 1'b0));
    send_req(make_req(lbe_pkg::OP_REFRESH, 48'd200, 16'h7fff, 1'b1));
    send_req(make_req(lbe_pkg::OP_SAMPLE, 48'd500_000, 16'h8000, 1'b1));
    send_req(make_req(lbe_pkg::OP_SAMPLE, 48'd1_100_000, 16'd15000, 1'b0));
    send_req(make_req(lbe_pkg::OP_REFRESH, 48'd1_200_000, 16'd0, 1'b1));
    send_req(make_req(lbe_pkg::OP_REFRESH, STAMP_MAX, 16'hffff, 1'b0));
    send_req(make_req(lbe_pkg::OP_SAMPLE, STAMP_MAX, 16'd1, 1'b1));
    send_req(make_req(lbe_pkg::OP_SAMPLE, 48'd5, 16'd30000, 1'b0));
    send_req(make_req(lbe_pkg::OP_REFRESH, 48'd2_000_000, 16'd0, 1'b1));
    release_input();
    wait_idle();
  endtask

  // both accumulators run into saturation, then a full-scale refresh
  task automatic test_charge_saturation();
    logic [47:0] stamp;
    write_reg(lbe_pkg::CFG_MAX_CURRENT, 32'd32767);
    write_reg(lbe_pkg::CFG_REFRESH_WINDOW, 32'hffff_ffff);
    stamp = 48'h1000;
    send_req(make_req(lbe_pkg::OP_REFRESH, stamp, 16'd0, 1'b0));
    send_req(make_req(lbe_pkg::OP_SAMPLE, stamp, 16'h7fff, 1'b0));
    for (int n = 0; n < 4; n++) begin
      stamp = stamp + 48'(HALF_WRAP);
      send_req(make_req(lbe_pkg::OP_SAMPLE, stamp, 16'h7fff, 1'b0));
    end
    send_req(make_req(lbe_pkg::OP_REFRESH, stamp + 48'(HALF_WRAP), 16'd0, 1'b1));
    release_input();
    wait_idle();
  endtask

  // zero full scale acts as one; window reached but not exceeded
  task automatic test_zero_full_scale();
    write_reg(lbe_pkg::CFG_MAX_CURRENT, 32'd0);
    write_reg(lbe_pkg::CFG_REFRESH_WINDOW, 32'd1);
    send_req(make_req(lbe_pkg::OP_SAMPLE, 48'd0, 16'd5, 1'b1));
    send_req(make_req(lbe_pkg::OP_REFRESH, 48'd10, 16'd0, 1'b1));
    send_req(make_req(lbe_pkg::OP_REFRESH, 48'd11, 16'd0, 1'b1));
    send_req(make_req(lbe_pkg::OP_REFRESH, 48'd13, 16'd0, 1'b1));
    release_input();
    wait_idle();
  endtask

  // receiver holds off while requests keep coming, so the block backs up
  task automatic test_output_hold_off();
    logic [47:0] stamp;
    write_reg(lbe_pkg::CFG_MAX_CURRENT, 32'd20000);
    write_reg(lbe_pkg::CFG_REFRESH_WINDOW, 32'd300);
    hold_off_req = 1'b1;
    burst_mode = 1'b1;
    while (hold_off_req) @(posedge clk_i);
    stamp = last_stamp;
    for (int n = 0; n < 16; n++) begin
      stamp = stamp + 48'($urandom_range(1, 200));
      send_req(make_req((n % 3 == 2) ? lbe_pkg::OP_REFRESH : lbe_pkg::OP_SAMPLE, stamp,
                        16'($urandom_range(0, 20000)), 1'b1));
    end
    burst_mode = 1'b0;
    release_input();
    wait_idle();
  endtask

  // mostly steady time and current sequences with refreshes, some noise
  task automatic test_random_phase(logic [31:0] scale_word, logic [31:0] window_word);
    longint unsigned    step;
    logic [47:0]        stamp;
    logic signed [15:0] cur;
    int unsigned        ceiling;
    int unsigned        pick;
    write_reg(lbe_pkg::CFG_MAX_CURRENT, scale_word);
    write_reg(lbe_pkg::CFG_REFRESH_WINDOW, window_word);
    step = 64'(window_ticks) / 3 + 1;
    stamp = last_stamp;
    ceiling = 32'(full_scale_ua);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_req(make_req(1'($urandom), rand_stamp(), 16'($urandom), 1'($urandom)));
      end else begin
        stamp = stamp + 48'(64'(rand_stamp()) % (2 * step + 1));
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          cur = 16'($urandom);
        end else if (pick < 12) begin
          cur = 16'($urandom_range(0, 32767));
        end else begin
          cur = 16'($urandom_range(0, ceiling));
        end
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          send_req(make_req(lbe_pkg::OP_REFRESH, stamp, cur, 1'b1));
          ceiling = $urandom_range(0, full_scale_ua);
        end else if (pick < 28) begin
          send_req(make_req(lbe_pkg::OP_REFRESH, stamp, cur, 1'b0));
        end else begin
          send_req(make_req(lbe_pkg::OP_SAMPLE, stamp, cur, 1'($urandom)));
        end
      end
    end
    burst_mode = 1'b0;
    release_input();
    wait_idle();
  endtask

  // receiver stalls, with one long hold-off on demand
  initial begin : receiver_idling
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
      end else begin
        out_stall_i = !burst_mode && ($urandom_range(0, 99) < 40);
        repeat (idle_len() + 1) @(negedge clk_i);
      end
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    lbe_pkg::out_req_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_levels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("unexpected result: brightness %0d refreshed %0b",
                   out_data_o.brightness, out_data_o.refreshed);
        end
      end else begin
        want = expected_levels.pop_front();
        if (out_data_o.brightness !== want.brightness ||
            out_data_o.refreshed !== want.refreshed) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("mismatch: expected brightness %0d refreshed %0b, got %0d %0b",
                     want.brightness, want.refreshed,
                     out_data_o.brightness, out_data_o.refreshed);
          end
        end
      end
    end
  end

  // watchdog on cycles with no request taken on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // test sequence
  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = lbe_pkg::CFG_MAX_CURRENT;
    cfg_data_i = '0;
    burst_mode = 1'b0;
    hold_off_req = 1'b0;
    mismatch_count = 0;
    quiet_cycles = 0;
    full_scale_ua = 15'd30000;
    window_ticks = 32'd1000000;
    last_stamp = '0;
    held_current = '0;
    charge_acc = '0;
    ticks_acc = '0;
    level_now = LEVEL_DARK;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_levels();
    test_charge_saturation();
    test_zero_full_scale();
    test_output_hold_off();
    test_random_phase(32'd30000, 32'd1000000);
    test_random_phase(32'd32767, 32'hffff_ffff);
    test_random_phase(32'd1, 32'd1);
    test_random_phase({17'($urandom), 15'($urandom_range(1, 32767))}, $urandom);
    test_random_phase(32'd0, 32'd0);
    test_random_phase(32'($urandom_range(1, 32767)), 32'($urandom_range(1, 1000)));

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
